FILE: rtl/kpd_pkg.sv
// shared types, constants and codes for the key press duration classifier
// no dependencies

package kpd_pkg;

  // datapath widths
  localparam int unsigned KeyWidth   = 16;
  localparam int unsigned TimerWidth = 16;
  localparam int unsigned FlagWidth  = 5;
  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  // register reset values
  localparam logic [KeyWidth-1:0]   IdleKeyReset    = '0;
  localparam logic [TimerWidth-1:0] ShortReset      = TimerWidth'(100);
  localparam logic [TimerWidth-1:0] LongFirstReset  = TimerWidth'(2000);
  localparam logic [TimerWidth-1:0] LongSecondReset = TimerWidth'(5000);

  // saturation point of the hold timer
  localparam logic [TimerWidth-1:0] TimerMax = '1;

  // flag bit positions
  localparam int unsigned FlRelease    = 0;
  localparam int unsigned FlShortOn    = 1;
  localparam int unsigned FlLongFirst  = 2;
  localparam int unsigned FlLongSecond = 3;
  localparam int unsigned FlShortOff   = 4;

  // request kinds
  typedef enum logic [1:0] {
    KindTick  = 2'd0,
    KindSet   = 2'd1,
    KindClear = 2'd2
  } kind_e;

  // press phases
  typedef enum logic [1:0] {
    PhIdle     = 2'd0,
    PhPressed  = 2'd1,
    PhReleased = 2'd2,
    PhTimeout  = 2'd3
  } phase_e;

  // configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CfgIdleKey    = 2'd0,
    CfgShort      = 2'd1,
    CfgLongFirst  = 2'd2,
    CfgLongSecond = 2'd3
  } cfg_idx_e;

  // configuration register bank
  typedef struct packed {
    logic [KeyWidth-1:0]   idle_key;
    logic [TimerWidth-1:0] short_thr;
    logic [TimerWidth-1:0] long_first_thr;
    logic [TimerWidth-1:0] long_second_thr;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic [KeyWidth-1:0]   current_key;
    logic [KeyWidth-1:0]   released_key;
    logic [1:0]            press_state;
    logic [TimerWidth-1:0] held_ticks;
    logic [FlagWidth-1:0]  event_flags;
    logic                  mask_all_set;
  } result_t;

endpackage

FILE: rtl/kpd_cfg_regs.sv
// configuration register bank of the key press duration classifier
// depends on kpd_pkg

module kpd_cfg_regs import kpd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q;

  // register writes by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_key        <= IdleKeyReset;
      cfg_q.short_thr       <= ShortReset;
      cfg_q.long_first_thr  <= LongFirstReset;
      cfg_q.long_second_thr <= LongSecondReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgIdleKey:    cfg_q.idle_key        <= cfg_data_i[KeyWidth-1:0];
        CfgShort:      cfg_q.short_thr       <= cfg_data_i[TimerWidth-1:0];
        CfgLongFirst:  cfg_q.long_first_thr  <= cfg_data_i[TimerWidth-1:0];
        CfgLongSecond: cfg_q.long_second_thr <= cfg_data_i[TimerWidth-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/kpd_press_fsm.sv
// press tracking state and per-request update logic
// depends on kpd_pkg

module kpd_press_fsm import kpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  req_i,
  input  logic [1:0]            kind_i,
  input  logic [KeyWidth-1:0]   key_code_i,
  input  logic                  power_on_i,
  input  logic [FlagWidth-1:0]  event_mask_i,
  output result_t               result_o
);

  logic [KeyWidth-1:0]   last_key_q, last_key_d;
  logic [KeyWidth-1:0]   rel_key_q, rel_key_d;
  phase_e                phase_q, phase_d;
  logic [TimerWidth-1:0] hold_q, hold_d;
  logic [FlagWidth-1:0]  flags_q, flags_d;

  // next state for one request
  always_comb begin
    last_key_d = last_key_q;
    rel_key_d  = rel_key_q;
    phase_d    = phase_q;
    hold_d     = hold_q;
    flags_d    = flags_q;
    case (kind_e'(kind_i))
      KindTick: begin
        // key change: new press or release
        if (key_code_i != last_key_q) begin
          last_key_d = key_code_i;
          if (key_code_i != cfg_i.idle_key) begin
            phase_d = PhPressed;
            hold_d  = '0;
            flags_d = '0;
          end else begin
            rel_key_d = last_key_q;
            if (hold_q > cfg_i.short_thr) begin
              phase_d = PhReleased;
              flags_d[FlRelease] = 1'b1;
            end else begin
              phase_d = PhIdle;
            end
          end
        end
        // timing while held
        if (phase_d == PhPressed) begin
          if (hold_d != TimerMax) begin
            hold_d = hold_d + TimerWidth'(1);
          end
          if (power_on_i) begin
            if (hold_d == cfg_i.long_second_thr) begin
              flags_d[FlLongSecond] = 1'b1;
            end else if (hold_d == cfg_i.long_first_thr) begin
              flags_d[FlLongFirst] = 1'b1;
            end else if (hold_d == cfg_i.short_thr) begin
              flags_d[FlShortOn] = 1'b1;
            end
          end else if (hold_d == cfg_i.short_thr) begin
            flags_d[FlShortOff] = 1'b1;
          end
          if (hold_d > cfg_i.long_second_thr) begin
            phase_d = PhTimeout;
          end
        end
      end
      KindSet:   flags_d = flags_q | event_mask_i;
      KindClear: flags_d = flags_q & ~event_mask_i;
      default: ;
    endcase
  end

  // result of this request
  always_comb begin
    result_o.current_key  = last_key_d;
    result_o.released_key = rel_key_d;
    result_o.press_state  = phase_d;
    result_o.held_ticks   = hold_d;
    result_o.event_flags  = flags_d;
    result_o.mask_all_set = ((flags_d & event_mask_i) == event_mask_i);
  end

  // state update on accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_key_q <= '0;
      rel_key_q  <= '0;
      phase_q    <= PhIdle;
      hold_q     <= '0;
      flags_q    <= '0;
    end else if (req_i) begin
      last_key_q <= last_key_d;
      rel_key_q  <= rel_key_d;
      phase_q    <= phase_d;
      hold_q     <= hold_d;
      flags_q    <= flags_d;
    end
  end

endmodule

FILE: rtl/kpd_out_buf.sv
// two-entry result queue between the update logic and the output channel
// depends on kpd_pkg

module kpd_out_buf import kpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    stall_i,
  output result_t data_o
);

  logic [1:0] cnt_q, cnt_d;
  result_t    slot0_q, slot1_q;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign pop     = valid_o && !stall_i;
  assign data_o  = slot0_q;

  // fill count
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // payload slots, head is slot0
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (push_i) begin
        if (cnt_q == 2'd1) begin
          slot0_q <= data_i;
        end else begin
          slot0_q <= slot1_q;
          slot1_q <= data_i;
        end
      end else begin
        slot0_q <= slot1_q;
      end
    end else if (push_i) begin
      if (cnt_q == 2'd0) begin
        slot0_q <= data_i;
      end else begin
        slot1_q <= data_i;
      end
    end
  end

endmodule

FILE: rtl/key_press_duration_classifier_core.sv
// top level of the key press duration classifier
// depends on kpd_pkg, kpd_cfg_regs, kpd_press_fsm, kpd_out_buf

// Takes one request per clock while in_stall_o is low and returns exactly
// one result per request. A tick request carries the sampled key code and
// power state; set and clear requests modify the sticky event flags by
// mask. The state update and result are formed in the cycle of acceptance
// and registered in a two-entry output queue, so the input keeps accepting
// back to back while fewer than two results wait. in_stall_o rises only
// when both queue entries are occupied. Configuration writes take effect
// on the next edge and should be issued while idle.

module key_press_duration_classifier_core import kpd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  // request channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              in_kind_i,
  input  logic [KeyWidth-1:0]     in_key_code_i,
  input  logic                    in_power_on_i,
  input  logic [FlagWidth-1:0]    in_event_mask_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [KeyWidth-1:0]     out_current_key_o,
  output logic [KeyWidth-1:0]     out_released_key_o,
  output logic [1:0]              out_press_state_o,
  output logic [TimerWidth-1:0]   out_held_ticks_o,
  output logic [FlagWidth-1:0]    out_event_flags_o,
  output logic                    out_mask_all_set_o
);

  cfg_t    cfg;
  result_t result;
  result_t head;
  logic    full;
  logic    req;

  assign in_stall_o = full;
  assign req        = in_valid_i && !full;

  kpd_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  kpd_press_fsm u_fsm (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg),
    .req_i        (req),
    .kind_i       (in_kind_i),
    .key_code_i   (in_key_code_i),
    .power_on_i   (in_power_on_i),
    .event_mask_i (in_event_mask_i),
    .result_o     (result)
  );

  kpd_out_buf u_buf (
    .clk_i,
    .rst_ni,
    .push_i  (req),
    .data_i  (result),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (head)
  );

  // result fields
  assign out_current_key_o  = head.current_key;
  assign out_released_key_o = head.released_key;
  assign out_press_state_o  = head.press_state;
  assign out_held_ticks_o   = head.held_ticks;
  assign out_event_flags_o  = head.event_flags;
  assign out_mask_all_set_o = head.mask_all_set;

endmodule

FILE: rtl/kpd_checker.sv
// port-level checks for the key press duration classifier
// depends on kpd_pkg; bound to key_press_duration_classifier_core

module kpd_checker import kpd_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [KeyWidth-1:0]     out_current_key_o,
  input logic [1:0]              out_press_state_o,
  input logic [TimerWidth-1:0]   out_held_ticks_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_current_key_o)
      && $stable(out_held_ticks_o))
    else $error("stalled result changed");

  // the input only stalls while results are queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty queue");

  // a drained output frees the input on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |=> !in_stall_o)
    else $error("input stalled after queue was empty");

  // a press in progress has counted at least one tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_press_state_o == PhPressed || out_press_state_o == PhTimeout)
      |-> out_held_ticks_o != '0)
    else $error("press reported with zero hold time");

endmodule

bind key_press_duration_classifier_core kpd_checker u_kpd_checker (.*);

FILE: bench/key_press_duration_classifier_core_test.sv
// self-checking testbench for key_press_duration_classifier_core
// depends on kpd_pkg and the core rtl, predicts every result and checks it on the fly

module key_press_duration_classifier_core_test;
  import kpd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // kind code with no meaning in the block
  localparam logic [1:0] KindUnused = 2'd3;
  // cycles with no handshake before the run is abandoned
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned MaxReported = 10;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxWidth-1:0]  cfg_idx_i;
  logic [CfgDataWidth-1:0] cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [1:0]              in_kind_i;
  logic [KeyWidth-1:0]     in_key_code_i;
  logic                    in_power_on_i;
  logic [FlagWidth-1:0]    in_event_mask_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [KeyWidth-1:0]     out_current_key_o;
  logic [KeyWidth-1:0]     out_released_key_o;
  logic [1:0]              out_press_state_o;
  logic [TimerWidth-1:0]   out_held_ticks_o;
  logic [FlagWidth-1:0]    out_event_flags_o;
  logic                    out_mask_all_set_o;

  key_press_duration_classifier_core i_dut (.*);

  // predicted block state and active settings
  cfg_t                  settings;
  logic [KeyWidth-1:0]   held_key;
  logic [KeyWidth-1:0]   last_released_key;
  phase_e                press_phase;
  logic [TimerWidth-1:0] hold_ticks;
  logic [FlagWidth-1:0]  sticky_flags;

  result_t     expected_results[$];
  int unsigned mismatches;
  int unsigned sent_count;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned rx_hold_request;
  bit          in_fired;
  bit          out_fired;

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // next state and result of the block for one request
  function automatic result_t classify_request(logic [1:0] kind, logic [KeyWidth-1:0] key,
                                               logic power, logic [FlagWidth-1:0] mask);
    result_t r;
    logic    to_idle;
    if (kind == KindTick) begin
      if (key != held_key) begin
        to_idle = (key == settings.idle_key);
        if (to_idle) last_released_key = held_key;
        held_key = key;
        if (!to_idle) begin
          press_phase  = PhPressed;
          hold_ticks   = '0;
          sticky_flags = '0;
        end else if (hold_ticks > settings.short_thr) begin
          press_phase = PhReleased;
          sticky_flags[FlRelease] = 1'b1;
        end else begin
          press_phase = PhIdle;
        end
      end
      if (press_phase == PhPressed) begin
        if (hold_ticks != TimerMax) hold_ticks = hold_ticks + TimerWidth'(1);
        // with power on only one threshold flag per tick, longest first
        if (power) begin
          if (hold_ticks == settings.long_second_thr) sticky_flags[FlLongSecond] = 1'b1;
          else if (hold_ticks == settings.long_first_thr) sticky_flags[FlLongFirst] = 1'b1;
          else if (hold_ticks == settings.short_thr) sticky_flags[FlShortOn] = 1'b1;
        end else if (hold_ticks == settings.short_thr) begin
          sticky_flags[FlShortOff] = 1'b1;
        end
        if (hold_ticks > settings.long_second_thr) press_phase = PhTimeout;
      end
    end else if (kind == KindSet) begin
      sticky_flags = sticky_flags | mask;
    end else if (kind == KindClear) begin
      sticky_flags = sticky_flags & ~mask;
    end
    r.current_key  = held_key;
    r.released_key = last_released_key;
    r.press_state  = press_phase;
    r.held_ticks   = hold_ticks;
    r.event_flags  = sticky_flags;
    r.mask_all_set = ((sticky_flags & mask) == mask);
    return r;
  endfunction

  // offer one request, wait for acceptance, record its expected result
  task automatic send_request(logic [1:0] kind, logic [KeyWidth-1:0] key, logic power,
                              logic [FlagWidth-1:0] mask);
    bit taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_kind_i       <= kind;
    in_key_code_i   <= key;
    in_power_on_i   <= power;
    in_event_mask_i <= mask;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    expected_results.push_back(classify_request(kind, key, power, mask));
    sent_count++;
  endtask

  // stop offering and let every outstanding result come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // write all four registers while the block is idle
  task automatic load_settings(cfg_t c);
    cfg_idx_e              idx;
    logic [CfgDataWidth-1:0] data;
    wait_drained();
    idx = idx.first();
    repeat (4) begin
      case (idx)
        CfgIdleKey:    data = c.idle_key;
        CfgShort:      data = c.short_thr;
        CfgLongFirst:  data = c.long_first_thr;
        CfgLongSecond: data = c.long_second_thr;
        default:       data = '0;
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= data;
      @(posedge clk_i);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
    settings = c;
  endtask

  task automatic set_idling(int unsigned tx_pct, int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MaxReported)
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  // one press with random content, optionally cut short
  task automatic press_and_release(bit broken);
    logic [KeyWidth-1:0] key;
    logic                power;
    int unsigned         ticks;
    int unsigned         span;
    do begin
      key = ($urandom_range(3) == 0) ? held_key : KeyWidth'($urandom);
    end while (key == settings.idle_key);
    power = 1'($urandom_range(1));
    span  = (settings.long_second_thr < 37) ? settings.long_second_thr + 3 : 40;
    ticks = $urandom_range(span, 1);
    if (broken) ticks = $urandom_range(ticks, 1);
    repeat (ticks) begin
      if ($urandom_range(9) == 0)
        send_request($urandom_range(1) ? KindSet : KindClear, KeyWidth'($urandom),
                     1'($urandom_range(1)), FlagWidth'($urandom_range(31)));
      if ($urandom_range(19) == 0) power = !power;
      send_request(KindTick, key, power, FlagWidth'($urandom_range(31)));
    end
    // a cut-short press may run straight into the next key
    if (!broken || $urandom_range(1))
      repeat ($urandom_range(3, 1))
        send_request(KindTick, settings.idle_key, 1'($urandom_range(1)),
                     FlagWidth'($urandom_range(31)));
  endtask

  // field extremes, every request kind, threshold order and power off
  task automatic test_directed();
    send_request(KindUnused, 16'hFFFF, 1'b1, 5'h1F);
    send_request(KindSet, 16'h0000, 1'b0, 5'h00);
    send_request(KindSet, 16'hFFFF, 1'b1, 5'h1F);
    send_request(KindClear, 16'h0000, 1'b0, 5'h15);
    send_request(KindClear, 16'hFFFF, 1'b1, 5'h1F);
    // short thresholds so every flag is reached quickly
    load_settings('{16'h0000, 16'd2, 16'd4, 16'd6});
    repeat (7) send_request(KindTick, 16'hFFFF, 1'b1, 5'h0E);
    send_request(KindTick, 16'h0000, 1'b1, 5'h01);
    // power off only raises short-off, and a short hold releases to idle
    repeat (2) send_request(KindTick, 16'h0001, 1'b0, 5'h10);
    send_request(KindTick, 16'h0000, 1'b0, 5'h1F);
    // all thresholds equal: the second long flag wins
    load_settings('{16'hFFFF, 16'd3, 16'd3, 16'd3});
    repeat (4) send_request(KindTick, 16'h5A5A, 1'b1, 5'h08);
    send_request(KindTick, 16'hFFFF, 1'b1, 5'h01);
    // key changes straight to another key
    send_request(KindTick, 16'h1234, 1'b1, 5'h00);
    send_request(KindTick, 16'h4321, 1'b0, 5'h1F);
    wait_drained();
  endtask

  // mostly well-formed presses under changing settings, plus noise
  task automatic test_random_presses(int unsigned count);
    int unsigned stop_at;
    int unsigned next_cfg;
    int unsigned choice;
    cfg_t        c;
    stop_at  = sent_count + count;
    next_cfg = sent_count;
    while (sent_count < stop_at) begin
      if (sent_count >= next_cfg) begin
        choice = $urandom_range(9);
        if (choice == 0) begin
          c = '{KeyWidth'($urandom), 16'd1, 16'd1, 16'd1};
        end else if (choice == 1) begin
          c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE};
        end else begin
          c.idle_key = ($urandom_range(2) == 0) ? KeyWidth'($urandom) :
                       ($urandom_range(1) ? 16'h0000 : 16'hFFFF);
          c.short_thr       = TimerWidth'($urandom_range(8, 1));
          c.long_first_thr  = TimerWidth'($urandom_range(16, 1));
          c.long_second_thr = TimerWidth'($urandom_range(24, 1));
        end
        load_settings(c);
        next_cfg = sent_count + 120;
      end
      choice = $urandom_range(99);
      if (choice < 70) begin
        press_and_release(1'b0);
      end else if (choice < 85) begin
        repeat ($urandom_range(4, 1))
          send_request(2'($urandom_range(3)), KeyWidth'($urandom), 1'($urandom_range(1)),
                       FlagWidth'($urandom_range(31)));
      end else begin
        press_and_release(1'b1);
      end
    end
    wait_drained();
  endtask

  // long output hold-off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    rx_hold_request = 60;
    repeat (24)
      send_request(2'($urandom_range(2)), ($urandom_range(1) ? settings.idle_key : 16'hC3C3),
                   1'($urandom_range(1)), FlagWidth'($urandom_range(31)));
    wait_drained();
  endtask

  // a second long threshold at the top of the timer range never times out
  task automatic test_timer_limit();
    load_settings('{16'h0000, 16'd1, 16'd2, TimerMax});
    repeat (40) send_request(KindTick, 16'hA5A5, 1'b1, 5'h0C);
    send_request(KindTick, 16'h0000, 1'b1, 5'h0D);
    wait_drained();
  endtask

  // result side: stall pattern and long hold-off
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_request != 0) begin
        hold_left       = rx_hold_request;
        rx_hold_request = 0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(negedge clk_i) begin
    result_t want;
    in_fired  = rst_ni && in_valid_i && !in_stall_o;
    out_fired = rst_ni && out_valid_o && !out_stall_i;
    if (out_fired) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported) $display("result with no request outstanding");
      end else begin
        want = expected_results.pop_front();
        check_field("current_key", want.current_key, out_current_key_o);
        check_field("released_key", want.released_key, out_released_key_o);
        check_field("press_state", want.press_state, out_press_state_o);
        check_field("held_ticks", want.held_ticks, out_held_ticks_o);
        check_field("event_flags", want.event_flags, out_event_flags_o);
        check_field("mask_all_set", want.mask_all_set, out_mask_all_set_o);
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if (!rst_ni || in_fired || out_fired) quiet = 0;
      else quiet++;
    end
    $display("key_press_duration_classifier_core_test failed");
    $finish;
  end

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CfgIdleKey;
    cfg_data_i      <= '0;
    in_valid_i      <= 1'b0;
    in_kind_i       <= KindTick;
    in_key_code_i   <= '0;
    in_power_on_i   <= 1'b0;
    in_event_mask_i <= '0;
    settings          = '{IdleKeyReset, ShortReset, LongFirstReset, LongSecondReset};
    held_key          = '0;
    last_released_key = '0;
    press_phase       = PhIdle;
    hold_ticks        = '0;
    sticky_flags      = '0;
    mismatches        = 0;
    sent_count        = 0;
    rx_hold_request   = 0;
    set_idling(13, 77);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_presses(420);
    set_idling(77, 13);
    test_random_presses(420);
    set_idling(0, 0);
    test_backpressure();
    test_timer_limit();
    test_random_presses(420);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("key_press_duration_classifier_core_test passed");
    else
      $display("key_press_duration_classifier_core_test failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/kpd_pkg.sv
rtl/kpd_cfg_regs.sv
rtl/kpd_press_fsm.sv
rtl/kpd_out_buf.sv
rtl/key_press_duration_classifier_core.sv
rtl/kpd_checker.sv
bench/key_press_duration_classifier_core_test.sv
